// ----- sv/pec10_frame_checker_macros.svh -----
// Assertion macros for the pec10 frame checker.
// Expects signals named clk and rst in the scope that uses them.
`ifndef PEC10_FRAME_CHECKER_MACROS_SVH
`define PEC10_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PEC10_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PEC10_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset
`define PEC10_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pec10_pkg.sv -----
// Package for the pec10 frame checker: constants, field widths and CRC functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pec10_pkg;

  localparam int unsigned CrcW     = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CntW     = 6;
  localparam int unsigned LenW     = 7;

  localparam logic [CrcW-1:0]  CRC_INIT     = 10'd16;
  localparam logic [CrcW-1:0]  CRC_TAPS     = 10'h08F;
  localparam logic [LenW-1:0]  MAX_DATA_LEN = 7'd64;
  localparam logic [LenW-1:0]  LEN_RESET    = 7'd6;

  typedef logic [CrcW-1:0] crc_t;

  // One bit into the CRC, polynomial x^10+x^7+x^3+x^2+x+1
  function automatic crc_t crc_bit(input crc_t crc, input logic din);
    logic fb;
    crc_t sh;
    fb = din ^ crc[CrcW-1];
    sh = {crc[CrcW-2:0], 1'b0};
    return fb ? (sh ^ CRC_TAPS) : sh;
  endfunction

  // Full byte, MSB first
  function automatic crc_t crc_byte(input crc_t crc, input logic [ByteW-1:0] din);
    crc_t c;
    c = crc;
    for (int k = ByteW - 1; k >= 0; k--) begin
      c = crc_bit(c, din[k]);
    end
    return c;
  endfunction

  // Six counter bits, MSB first
  function automatic crc_t crc_cnt(input crc_t crc, input logic [CntW-1:0] din);
    crc_t c;
    c = crc;
    for (int k = CntW - 1; k >= 0; k--) begin
      c = crc_bit(c, din[k]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/pec10_if.sv -----
// Valid/ready channel interfaces for the pec10 frame checker: byte words and result words.
// Depends on pec10_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pec10_byte_if
  import pec10_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface pec10_result_if
  import pec10_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            pec_ok;
  logic [CrcW-1:0] received_pec;
  logic [CrcW-1:0] computed_pec;
  logic [CntW-1:0] command_counter;

  modport source (output valid, output pec_ok, output received_pec,
                  output computed_pec, output command_counter, input ready);
  modport sink   (input valid, input pec_ok, input received_pec,
                  input computed_pec, input command_counter, output ready);
endinterface

`default_nettype wire

// ----- sv/pec10_frame_checker.sv -----
// A result word is registered and appears in the cycle after the second trailer byte is accepted.
// Throughput: one byte word per cycle while the input is not stalled; the byte CRC update
// and the counter feed are combinational logic in front of the CRC and result registers.
// Input stalls only while a result word is held and the sink is not ready.
// Reset (rst, synchronous): data_length = 6, CRC = 16, byte count 0, no result held.
// Depends on pec10_pkg and pec10_if.
`timescale 1ns / 1ps
`default_nettype none

module pec10_frame_checker
  import pec10_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [LenW-1:0] cfg_wr_data,
  pec10_byte_if.sink           frame,
  pec10_result_if.source       result
);

  logic [LenW-1:0]  data_length;
  crc_t             crc;
  logic [LenW-1:0]  pos;
  logic [ByteW-1:0] trailer_high_byte;

  logic             res_valid;
  logic             res_ok;
  crc_t             res_rx;
  crc_t             res_calc;
  logic [CntW-1:0]  res_cnt;

  logic             accept;
  logic [LenW-1:0]  len_eff;
  logic [LenW-1:0]  pos_base;
  crc_t             crc_base;
  logic             is_data;
  logic             is_trailer1;
  logic [CntW-1:0]  cnt_rx;
  crc_t             pec_rx;
  crc_t             pec_calc;

  // Output register frees up when taken, so a byte can enter under a draining result
  assign frame.ready = !res_valid || result.ready;
  assign accept      = frame.valid && frame.ready;

  // Frame position decode
  assign len_eff     = (data_length > MAX_DATA_LEN) ? MAX_DATA_LEN : data_length;
  assign pos_base    = frame.frame_start ? '0 : pos;
  assign crc_base    = frame.frame_start ? CRC_INIT : crc;
  assign is_data     = pos_base < len_eff;
  assign is_trailer1 = pos_base == len_eff;

  // Trailer check: counter bits go into the CRC, then compare
  assign cnt_rx   = trailer_high_byte[ByteW-1:2];
  assign pec_rx   = {trailer_high_byte[1:0], frame.data_byte};
  assign pec_calc = crc_cnt(crc_base, cnt_rx);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      data_length <= LEN_RESET;
    end else if (cfg_wr_en) begin
      data_length <= cfg_wr_data;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc               <= CRC_INIT;
      pos               <= '0;
      trailer_high_byte <= '0;
    end else if (accept) begin
      if (is_data) begin
        crc <= crc_byte(crc_base, frame.data_byte);
        pos <= pos_base + 1'b1;
      end else if (is_trailer1) begin
        crc               <= crc_base;
        trailer_high_byte <= frame.data_byte;
        pos               <= pos_base + 1'b1;
      end else begin
        crc <= CRC_INIT;
        pos <= '0;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && !is_data && !is_trailer1) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept && !is_data && !is_trailer1) begin
      res_ok   <= pec_rx == pec_calc;
      res_rx   <= pec_rx;
      res_calc <= pec_calc;
      res_cnt  <= cnt_rx;
    end
  end

  assign result.valid           = res_valid;
  assign result.pec_ok          = res_ok;
  assign result.received_pec    = res_rx;
  assign result.computed_pec    = res_calc;
  assign result.command_counter = res_cnt;

endmodule

`default_nettype wire

// ----- sv/pec10_checker.sv -----
// Port-level checks for the pec10 frame checker, bound to the top level.
// Depends on pec10_pkg and pec10_frame_checker_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "pec10_frame_checker_macros.svh"

module pec10_checker
  import pec10_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            frame_ready,
  input wire logic            res_valid,
  input wire logic            res_ready,
  input wire logic            res_ok,
  input wire logic [CrcW-1:0] res_rx,
  input wire logic [CrcW-1:0] res_calc
);

  // A held result stays until taken
  `PEC10_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
  // Match flag agrees with the two PEC fields
  `PEC10_ASSERT_NOW(a_ok_match, res_valid, res_ok == (res_rx == res_calc), "pec_ok inconsistent")
  // Input is open whenever nothing is waiting at the output
  `PEC10_ASSERT_NOW(a_ready_free, !res_valid || res_ready, frame_ready, "input blocked without cause")
  // Nothing is shown right after reset
  `PEC10_ASSERT_RST(a_reset_clear, rst, !res_valid, "result valid after reset")

endmodule

bind pec10_frame_checker pec10_checker u_pec10_checker (
  .clk        (clk),
  .rst        (rst),
  .frame_ready(frame.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_ok     (result.pec_ok),
  .res_rx     (result.received_pec),
  .res_calc   (result.computed_pec)
);

`default_nettype wire
